@@ design/spd_pkg.sv @@
// Shared constants, types and helpers for the slotted page directory.
package spd_pkg;

    // Page geometry
    localparam int PAGE_BYTES      = 4096;
    localparam int HDR_BYTES       = 12;
    localparam int ENTRY_BYTES     = 4;
    localparam int TUPLE_HDR_BYTES = 26;
    localparam int FIT_SLOTS       = (PAGE_BYTES - HDR_BYTES) / ENTRY_BYTES;
    localparam int SLOT_CAP        = (FIT_SLOTS > 1024) ? 1024 : FIT_SLOTS;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 13;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;

    // Dead-slot bitmap: 32 slots per word, one summary bit per word
    localparam int BM_BIT_W = 5;
    localparam int BM_BITS  = 1 << BM_BIT_W;
    localparam int BM_IDX_W = SLOT_W - BM_BIT_W;
    localparam int BM_WORDS = 1 << BM_IDX_W;

    // Shared adder width: holds a signed difference or an offset+length sum
    localparam int ALU_W = BYTE_W + 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [STAT_W-1:0] ST_DEAD     = 2'd3;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Request to the shared adder
    typedef struct packed {
        logic             go;
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // Index of the lowest set bit of a bitmap word
    function automatic logic [BM_BIT_W-1:0] lowest_set(input logic [BM_BITS-1:0] v);
        logic [BM_BIT_W-1:0] r;
        r = '0;
        for (int i = BM_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BM_BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ design/spd_alu.sv @@
// Shared add/subtract unit with a registered result.
module spd_alu import spd_pkg::*; (
    input  logic             aclk,
    input  alu_req_t         req,
    output logic [ALU_W-1:0] result
);

    logic [ALU_W-1:0] result_reg;
    logic [ALU_W-1:0] result_next;

    // One add or subtract per request
    always_comb begin
        case (req.op)
            ALU_ADD: result_next = req.a + req.b;
            ALU_SUB: result_next = req.a - req.b;
            default: result_next = req.a;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (req.go) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ design/slotted_page_directory.sv @@
// Slot directory and free-space bookkeeping of one slotted page.
//
// One request is handled at a time. After acceptance, init, zero-length and
// directory-full inserts and out-of-range deletes and lookups go from the
// execute step straight to the done step. Inserts that append a slot pass
// through the room check, deletes of an index below the slot count through the
// bitmap update, inserts that reuse a dead slot through the word search and the
// room check, and lookups below the slot count through the directory read and
// the bound check. s_ready returns in the cycle the result appears. These steps
// follow from the registered read ports of the directory and bitmap
// memories and by the single shared adder that serves the room check and the
// lookup bound check. The lowest dead slot
// is found through a 32-bit summary of a dead-slot bitmap memory, one summary
// priority encode and one word encode, so insert time does not grow with the
// slot count. Directory memories need no clearing: entries are read only below
// the slot count, and init completes in a single pass through the sequencer.
// A finished result sits in the output register while the next request may
// be accepted; that request holds in its last step until the register frees.
module slotted_page_directory import spd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_cmd,
    input  logic [BYTE_W-1:0] s_tuple_length,
    input  logic [SLOT_W-1:0] s_slot_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [SLOT_W-1:0] m_slot,
    output logic [BYTE_W-1:0] m_offset,
    output logic [BYTE_W-1:0] m_length
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_SRCH  = 8'b0000_0100,
        S_ROOM  = 8'b0000_1000,
        S_DMOD  = 8'b0001_0000,
        S_LKRD  = 8'b0010_0000,
        S_LKCHK = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   slot_count_reg, slot_count_next;
    logic [BYTE_W-1:0]    dir_end_reg, dir_end_next;
    logic [BYTE_W-1:0]    heap_start_reg, heap_start_next;
    logic [BM_WORDS-1:0]  summary_reg, summary_next;
    logic                 m_valid_reg, m_valid_next;

    // Request and result payload
    logic [CMD_W-1:0]     cmd_reg;
    logic [BYTE_W-1:0]    tlen_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic                 reuse_reg, reuse_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [BYTE_W-1:0]    res_offset_reg, res_offset_next;
    logic [BYTE_W-1:0]    res_length_reg, res_length_next;
    logic [STAT_W-1:0]    m_status_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [BYTE_W-1:0]    m_offset_reg;
    logic [BYTE_W-1:0]    m_length_reg;

    // Directory memories
    logic [BYTE_W-1:0]    ofs_mem [SLOT_CAP];
    logic [BYTE_W-1:0]    len_mem [SLOT_CAP];
    logic                 dir_we;
    logic [SLOT_W-1:0]    dir_waddr;
    logic [BYTE_W-1:0]    dir_wofs;
    logic [BYTE_W-1:0]    dir_wlen;
    logic                 dir_re;
    logic [SLOT_W-1:0]    dir_raddr;
    logic [BYTE_W-1:0]    ofs_rd_reg;
    logic [BYTE_W-1:0]    len_rd_reg;

    // Dead-slot bitmap memory
    logic [BM_BITS-1:0]   bm_mem [BM_WORDS];
    logic                 bm_we;
    logic [BM_IDX_W-1:0]  bm_waddr;
    logic [BM_BITS-1:0]   bm_wdata;
    logic                 bm_re;
    logic [BM_IDX_W-1:0]  bm_raddr;
    logic [BM_BITS-1:0]   bm_rd_reg;

    // Shared adder
    alu_req_t             alu_req;
    logic [ALU_W-1:0]     alu_result;

    // Datapath helpers
    logic                 accept;
    logic                 out_free;
    logic                 idx_bad;
    logic [BYTE_W:0]      room_need;
    logic                 room_fits;
    logic [BM_BITS-1:0]   bit_mask;
    logic [BM_BITS-1:0]   old_word;
    logic [BM_BITS-1:0]   cleared_word;
    logic                 lk_bad;

    spd_alu u_alu (
        .aclk   (aclk),
        .req    (alu_req),
        .result (alu_result)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_bad  = {1'b0, idx_reg} >= slot_count_reg;

    // Room check on the difference heap_start - tuple_length
    assign room_need = {1'b0, dir_end_reg}
                     + (reuse_reg ? (BYTE_W + 1)'(0) : (BYTE_W + 1)'(ENTRY_BYTES));
    assign room_fits = !alu_result[ALU_W-1] && (alu_result[BYTE_W:0] >= room_need);

    // Bitmap word edits; a word whose summary bit is clear reads as empty
    assign bit_mask     = BM_BITS'(1) << slot_reg[BM_BIT_W-1:0];
    assign old_word     = summary_reg[idx_reg[SLOT_W-1:BM_BIT_W]] ? bm_rd_reg : '0;
    assign cleared_word = bm_rd_reg & ~bit_mask;

    // Lookup sanity check
    assign lk_bad = (ofs_rd_reg == '0)
                 || (len_rd_reg < BYTE_W'(TUPLE_HDR_BYTES))
                 || (ofs_rd_reg < BYTE_W'(HDR_BYTES))
                 || (alu_result > ALU_W'(PAGE_BYTES));

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        slot_count_next = slot_count_reg;
        dir_end_next    = dir_end_reg;
        heap_start_next = heap_start_reg;
        summary_next    = summary_reg;
        m_valid_next    = m_valid_reg;
        reuse_next      = reuse_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_offset_next = res_offset_reg;
        res_length_next = res_length_reg;
        dir_we          = 1'b0;
        dir_waddr       = slot_reg;
        dir_wofs        = alu_result[BYTE_W-1:0];
        dir_wlen        = tlen_reg;
        dir_re          = 1'b0;
        dir_raddr       = idx_reg;
        bm_we           = 1'b0;
        bm_waddr        = slot_reg[SLOT_W-1:BM_BIT_W];
        bm_wdata        = cleared_word;
        bm_re           = 1'b0;
        bm_raddr        = lowest_set(summary_reg);
        alu_req.go      = 1'b0;
        alu_req.op      = ALU_SUB;
        alu_req.a       = ALU_W'(heap_start_reg);
        alu_req.b       = ALU_W'(tlen_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = ST_OK;
                res_slot_next   = '0;
                res_offset_next = '0;
                res_length_next = '0;
                state_next      = S_DONE;
                case (cmd_reg)
                    CMD_INIT: begin
                        slot_count_next = '0;
                        dir_end_next    = BYTE_W'(HDR_BYTES);
                        heap_start_next = BYTE_W'(PAGE_BYTES);
                        summary_next    = '0;
                    end
                    CMD_INSERT: begin
                        // start heap_start - length on every insert path
                        alu_req.go = 1'b1;
                        if (tlen_reg == '0) begin
                            res_status_next = ST_NO_ROOM;
                        end else if (summary_reg != '0) begin
                            bm_re      = 1'b1;
                            reuse_next = 1'b1;
                            slot_next  = {lowest_set(summary_reg), {BM_BIT_W{1'b0}}};
                            state_next = S_SRCH;
                        end else if (slot_count_reg >= COUNT_W'(SLOT_CAP)) begin
                            res_status_next = ST_NO_ROOM;
                        end else begin
                            reuse_next = 1'b0;
                            slot_next  = slot_count_reg[SLOT_W-1:0];
                            state_next = S_ROOM;
                        end
                    end
                    CMD_DELETE: begin
                        res_slot_next = idx_reg;
                        if (idx_bad) begin
                            res_status_next = ST_BAD_SLOT;
                        end else begin
                            dir_we     = 1'b1;
                            dir_waddr  = idx_reg;
                            dir_wofs   = '0;
                            dir_wlen   = '0;
                            bm_re      = 1'b1;
                            bm_raddr   = idx_reg[SLOT_W-1:BM_BIT_W];
                            state_next = S_DMOD;
                        end
                    end
                    CMD_LOOKUP: begin
                        res_slot_next = idx_reg;
                        if (idx_bad) begin
                            res_status_next = ST_BAD_SLOT;
                        end else begin
                            dir_re     = 1'b1;
                            state_next = S_LKRD;
                        end
                    end
                    default: begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_SRCH: begin
                // word is non-empty, its summary bit being set
                slot_next  = {slot_reg[SLOT_W-1:BM_BIT_W], lowest_set(bm_rd_reg)};
                state_next = S_ROOM;
            end
            S_ROOM: begin
                state_next = S_DONE;
                if (!room_fits) begin
                    res_status_next = ST_NO_ROOM;
                end else begin
                    dir_we          = 1'b1;
                    heap_start_next = alu_result[BYTE_W-1:0];
                    res_status_next = ST_OK;
                    res_slot_next   = slot_reg;
                    res_offset_next = alu_result[BYTE_W-1:0];
                    res_length_next = tlen_reg;
                    if (reuse_reg) begin
                        bm_we = 1'b1;
                        summary_next[slot_reg[SLOT_W-1:BM_BIT_W]] = |cleared_word;
                    end else begin
                        slot_count_next = slot_count_reg + COUNT_W'(1);
                        dir_end_next    = dir_end_reg + BYTE_W'(ENTRY_BYTES);
                    end
                end
            end
            S_DMOD: begin
                // mark the slot dead in its bitmap word
                bm_we      = 1'b1;
                bm_waddr   = idx_reg[SLOT_W-1:BM_BIT_W];
                bm_wdata   = old_word | (BM_BITS'(1) << idx_reg[BM_BIT_W-1:0]);
                summary_next[idx_reg[SLOT_W-1:BM_BIT_W]] = 1'b1;
                state_next = S_DONE;
            end
            S_LKRD: begin
                alu_req.go = 1'b1;
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(ofs_rd_reg);
                alu_req.b  = ALU_W'(len_rd_reg);
                state_next = S_LKCHK;
            end
            S_LKCHK: begin
                res_status_next = lk_bad ? ST_DEAD : ST_OK;
                res_offset_next = ofs_rd_reg;
                res_length_next = len_rd_reg;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slot_count_reg <= '0;
            dir_end_reg    <= BYTE_W'(HDR_BYTES);
            heap_start_reg <= BYTE_W'(PAGE_BYTES);
            summary_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            dir_end_reg    <= dir_end_next;
            heap_start_reg <= heap_start_next;
            summary_reg    <= summary_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_cmd;
            tlen_reg <= s_tuple_length;
            idx_reg  <= s_slot_index;
        end
        reuse_reg      <= reuse_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_offset_reg <= res_offset_next;
        res_length_reg <= res_length_next;
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_offset_reg <= res_offset_reg;
            m_length_reg <= res_length_reg;
        end
    end

    // Directory memories: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (dir_we) begin
            ofs_mem[dir_waddr] <= dir_wofs;
            len_mem[dir_waddr] <= dir_wlen;
        end
        if (dir_re) begin
            ofs_rd_reg <= ofs_mem[dir_raddr];
            len_rd_reg <= len_mem[dir_raddr];
        end
    end

    // Bitmap memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            bm_rd_reg <= bm_mem[bm_raddr];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;
    assign m_offset = m_offset_reg;
    assign m_length = m_length_reg;

    // Directory end tracks the slot count
    a_dir_end: assert property (@(posedge aclk) disable iff (!aresetn)
        dir_end_reg == BYTE_W'(HDR_BYTES) + {slot_count_reg, 2'b00})
        else $error("dir_end out of step with slot_count");

    // Free region never inverts
    a_free_order: assert property (@(posedge aclk) disable iff (!aresetn)
        dir_end_reg <= heap_start_reg)
        else $error("dir_end passed heap_start");

    // Slot count stays within the directory capacity
    a_slot_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_count_reg <= COUNT_W'(SLOT_CAP))
        else $error("slot_count beyond capacity");

    // A new request is not taken in the cycle after one is accepted
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

endmodule

@@ bench/tb_slotted_page_directory.sv @@
// Self-checking testbench for the slotted page directory: directed and random requests.
module tb_slotted_page_directory import spd_pkg::*; ();

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] offset;
        logic [BYTE_W-1:0] length;
    } page_result_t;

    // Page bookkeeping shadow plus the queue of results still owed by the block
    class page_ledger;
        logic [BYTE_W-1:0] tuple_off [SLOT_CAP];
        logic [BYTE_W-1:0] tuple_len [SLOT_CAP];
        int unsigned       used_slots;
        int unsigned       dir_end;
        int unsigned       heap_start;
        page_result_t      awaited[$];
        int                mismatches;

        function new();
            mismatches = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < SLOT_CAP; i++) begin
                tuple_off[i] = '0;
                tuple_len[i] = '0;
            end
            used_slots = 0;
            dir_end    = HDR_BYTES;
            heap_start = PAGE_BYTES;
        endfunction

        // Predict the result of one accepted request and update the page
        function void take_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] len,
                                   logic [SLOT_W-1:0] idx);
            int unsigned  tlen;
            int unsigned  slot;
            int unsigned  need;
            int unsigned  off;
            int unsigned  o;
            int unsigned  l;
            bit           reuse;
            page_result_t r;
            tlen     = len;
            slot     = used_slots;
            reuse    = 1'b0;
            r.status = ST_OK;
            r.slot   = '0;
            r.offset = '0;
            r.length = '0;
            case (cmd)
                CMD_INIT: begin
                    wipe();
                end
                CMD_INSERT: begin
                    if (tlen == 0) begin
                        r.status = ST_NO_ROOM;
                    end else begin
                        // lowest dead slot wins, else append
                        for (int i = 0; i < used_slots && !reuse; i++) begin
                            if (tuple_len[i] == 0) begin
                                slot  = i;
                                reuse = 1'b1;
                            end
                        end
                        need = tlen + (reuse ? 0 : ENTRY_BYTES);
                        if (!reuse && used_slots >= SLOT_CAP) begin
                            r.status = ST_NO_ROOM;
                        end else if (heap_start < dir_end + need) begin
                            r.status = ST_NO_ROOM;
                        end else begin
                            off        = heap_start - tlen;
                            heap_start = off;
                            if (!reuse) begin
                                used_slots++;
                                dir_end += ENTRY_BYTES;
                            end
                            tuple_off[slot] = BYTE_W'(off);
                            tuple_len[slot] = BYTE_W'(tlen);
                            r.slot   = SLOT_W'(slot);
                            r.offset = BYTE_W'(off);
                            r.length = BYTE_W'(tlen);
                        end
                    end
                end
                CMD_DELETE, CMD_LOOKUP: begin
                    r.slot = idx;
                    if (idx >= used_slots) begin
                        r.status = ST_BAD_SLOT;
                    end else if (cmd == CMD_DELETE) begin
                        tuple_off[idx] = '0;
                        tuple_len[idx] = '0;
                    end else begin
                        o = tuple_off[idx];
                        l = tuple_len[idx];
                        r.offset = tuple_off[idx];
                        r.length = tuple_len[idx];
                        if (o == 0 || l < TUPLE_HDR_BYTES || o < HDR_BYTES ||
                            o + l > PAGE_BYTES) begin
                            r.status = ST_DEAD;
                        end
                    end
                end
                default: begin
                    r.status = ST_OK;
                end
            endcase
            awaited.push_back(r);
        endfunction

        // Compare one delivered result with the oldest prediction
        function void match_result(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] sl,
                                   logic [BYTE_W-1:0] off, logic [BYTE_W-1:0] len);
            page_result_t e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: status=%0d slot=%0d offset=%0d length=%0d",
                             st, sl, off, len);
                end
                return;
            end
            e = awaited.pop_front();
            if (e.status !== st || e.slot !== sl || e.offset !== off || e.length !== len) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result differs: expected status=%0d slot=%0d offset=%0d length=%0d",
                             e.status, e.slot, e.offset, e.length);
                    $display("                actual   status=%0d slot=%0d offset=%0d length=%0d",
                             st, sl, off, len);
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd          = CMD_INIT;
    logic [BYTE_W-1:0] s_tuple_length = '0;
    logic [SLOT_W-1:0] s_slot_index   = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [SLOT_W-1:0] m_slot;
    logic [BYTE_W-1:0] m_offset;
    logic [BYTE_W-1:0] m_length;

    page_ledger ledger = new();

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_tog    = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    slotted_page_directory dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_tuple_length (s_tuple_length),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot         (m_slot),
        .m_offset       (m_offset),
        .m_length       (m_length)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: check accepted results, drive ready with random stalls and long holds
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.match_result(m_status, m_slot, m_offset, m_length);
        end
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one request, idling first at random; valid stays up across back-to-back requests
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] len,
                                logic [SLOT_W-1:0] idx);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_tuple_length <= len;
        s_slot_index   <= idx;
        do @(posedge aclk); while (!s_ready);
        ledger.take_request(cmd, len, idx);
    endtask

    // Stop offering until every predicted result has been delivered
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (ledger.awaited.size() != 0);
    endtask

    // Mixed request: mostly addresses live slots, with some noise out of range
    task automatic random_request();
        int unsigned       pick;
        int unsigned       n;
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] len;
        logic [SLOT_W-1:0] idx;
        n    = ledger.used_slots;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            len = '0;
        end else if (pick < 65) begin
            len = BYTE_W'($urandom_range(1, 40));
        end else if (pick < 92) begin
            len = BYTE_W'($urandom_range(26, 300));
        end else begin
            len = BYTE_W'($urandom_range(300, PAGE_BYTES));
        end
        if (n != 0 && $urandom_range(0, 99) < 85) begin
            idx = SLOT_W'($urandom_range(0, n - 1));
        end else begin
            idx = SLOT_W'($urandom());
        end
        pick = $urandom_range(0, 999);
        if (pick < 5) begin
            cmd = CMD_INIT;
        end else if (pick < 450) begin
            cmd = CMD_INSERT;
        end else if (pick < 680) begin
            cmd = CMD_DELETE;
        end else begin
            cmd = CMD_LOOKUP;
        end
        send_request(cmd, len, idx);
    endtask

    // Stimulus
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 8;
        rx_idle_pct = 57;

        // empty page: out-of-range slots, zero and oversized lengths
        send_request(CMD_LOOKUP, 13'd0, 10'd0);
        send_request(CMD_DELETE, 13'd4096, 10'd1023);
        send_request(CMD_INSERT, 13'd0, 10'd0);
        send_request(CMD_INSERT, 13'd4096, 10'd1023);
        // live, short and deleted slots, then reuse of the lowest dead one
        send_request(CMD_INSERT, 13'd26, 10'd512);
        send_request(CMD_INSERT, 13'd1, 10'd0);
        send_request(CMD_INSERT, 13'd100, 10'd0);
        send_request(CMD_LOOKUP, 13'd0, 10'd0);
        send_request(CMD_LOOKUP, 13'd0, 10'd1);
        send_request(CMD_DELETE, 13'd0, 10'd0);
        send_request(CMD_LOOKUP, 13'd0, 10'd0);
        send_request(CMD_DELETE, 13'd0, 10'd0);
        send_request(CMD_INSERT, 13'd30, 10'd0);
        send_request(CMD_DELETE, 13'd0, 10'd1);
        send_request(CMD_DELETE, 13'd0, 10'd2);
        send_request(CMD_INSERT, 13'd4095, 10'd0);
        send_request(CMD_LOOKUP, 13'd0, 10'd3);
        send_request(CMD_LOOKUP, 13'd8191, 10'd1023);
        // exact fit of a whole page, then no room for append or reuse
        send_request(CMD_INIT, 13'd0, 10'd0);
        send_request(CMD_INSERT, 13'd4080, 10'd0);
        send_request(CMD_INSERT, 13'd1, 10'd0);
        send_request(CMD_LOOKUP, 13'd0, 10'd0);
        send_request(CMD_DELETE, 13'd0, 10'd0);
        send_request(CMD_INSERT, 13'd1, 10'd0);
        send_request(CMD_INIT, 13'd0, 10'd0);

        // sender rarely idle, receiver often stalled; one long receiver hold
        for (int i = 0; i < 250; i++) begin
            if (i == 150) begin
                hold_tog <= ~hold_tog;
            end
            random_request();
        end
        wait_drained();

        tx_idle_pct = 57;
        rx_idle_pct = 8;
        for (int i = 0; i < 250; i++) begin
            random_request();
        end
        wait_drained();

        // no idling: fill the directory deep with tiny tuples, then mix
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_request(CMD_INIT, BYTE_W'($urandom()), SLOT_W'($urandom()));
        for (int i = 0; i < 500; i++) begin
            send_request(CMD_INSERT, BYTE_W'($urandom_range(1, 2)), SLOT_W'($urandom()));
        end
        for (int i = 0; i < 200; i++) begin
            if (i == 100) begin
                hold_tog <= ~hold_tog;
            end
            random_request();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
